[hw/rtl/debl_pkg.sv]
// ----------------------------------------------------------------------------
// Deblocking edge-line filter package
// Field widths and configuration register indexes shared by the block and its
// channel interfaces.
// ----------------------------------------------------------------------------
package debl_pkg;

  // Width of every pixel field on the channels.
  localparam int PIX_W = 16;

  // Width of every configuration register and of the write data.
  localparam int CFG_W = 16;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CFG_W-1:0] cfg_word_t;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA = 3'd0,
    REG_BETA  = 3'd1,
    REG_CLIP0 = 3'd2,
    REG_CLIP1 = 3'd3,
    REG_PEAK  = 3'd4
  } cfg_reg_t;

  // Reset value of the peak register.
  localparam cfg_word_t PEAK_RESET = 16'd255;

endpackage

[hw/rtl/debl_in_if.sv]
// ----------------------------------------------------------------------------
// Deblocking input channel
// Carries one line of six pixels across a block edge, with valid and ready.
// ----------------------------------------------------------------------------
interface debl_in_if;
  import debl_pkg::*;

  logic valid;
  logic ready;
  pix_t pix_p2;
  pix_t pix_p1;
  pix_t pix_p0;
  pix_t pix_q0;
  pix_t pix_q1;
  pix_t pix_q2;

  modport source (
    output valid, pix_p2, pix_p1, pix_p0, pix_q0, pix_q1, pix_q2,
    input  ready
  );

  modport sink (
    input  valid, pix_p2, pix_p1, pix_p0, pix_q0, pix_q1, pix_q2,
    output ready
  );

endinterface

[hw/rtl/debl_out_if.sv]
// ----------------------------------------------------------------------------
// Deblocking output channel
// Carries the four filtered inner pixels of one edge line, with valid and ready.
// ----------------------------------------------------------------------------
interface debl_out_if;
  import debl_pkg::*;

  logic valid;
  logic ready;
  pix_t out_p1;
  pix_t out_p0;
  pix_t out_q0;
  pix_t out_q1;

  modport source (
    output valid, out_p1, out_p0, out_q0, out_q1,
    input  ready
  );

  modport sink (
    input  valid, out_p1, out_p0, out_q0, out_q1,
    output ready
  );

endinterface

[hw/rtl/deblock_edge_line_filter.sv]
// ----------------------------------------------------------------------------
// Deblocking edge-line filter
// Normal-strength deblocking of one line of six pixels p2,p1,p0 | q0,q1,q2
// that crosses a block edge; returns the filtered inner pixels p1,p0,q0,q1.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on in_ch (valid/ready) and leave on out_ch (valid/ready); an
//   item moves at a rising edge where valid and ready are both high. Each
//   input item produces exactly one output item, in order.
//   Thresholds, clip limits and the output peak are set through the write
//   port (cfg_we, cfg_idx, cfg_data) while no item is in flight. Writes to
//   an index beyond the register map are dropped.
//   An item accepted on in_ch is registered in stage 1, then in stage 2, then
//   in the output register of stage 3 before it shows up on out_ch. Throughput
//   is one item per cycle while out_ch is ready, set by the three-stage
//   pipeline (edge decisions, clipping, update and saturation), each stage
//   holding one item. When the receiver stalls, each stage keeps its item
//   and only the stages behind a full stage stop; in_ch.ready falls once
//   all three stages are full. Nothing is dropped or repeated.
//   Reset (rst, synchronous, active high) empties the pipeline and returns
//   the registers to zero thresholds and a peak of 255.
// ----------------------------------------------------------------------------
module deblock_edge_line_filter #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [debl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [debl_pkg::CFG_W-1:0]     cfg_data,
  debl_in_if.sink                        in_ch,
  debl_out_if.source                     out_ch
);
  import debl_pkg::*;

  localparam int W = PIXEL_BITS;
  // Signed working width: holds 4*(q0-p0)+p1-q1+4 and the sum of clip limits.
  localparam int SW = (PIXEL_BITS + 4 > 19) ? PIXEL_BITS + 4 : 19;
  // Largest value a pixel of PIXEL_BITS bits can take.
  localparam cfg_word_t PIX_MAX = CFG_W'((64'd1 << PIXEL_BITS) - 64'd1);

  // Configuration registers.
  cfg_word_t alpha_limit;
  cfg_word_t beta_limit;
  cfg_word_t clip_base;
  cfg_word_t clip_extra;
  cfg_word_t pixel_peak;
  cfg_word_t peak_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_limit <= '0;
      beta_limit  <= '0;
      clip_base   <= '0;
      clip_extra  <= '0;
      pixel_peak  <= PEAK_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ALPHA: alpha_limit <= cfg_data;
        REG_BETA:  beta_limit  <= cfg_data;
        REG_CLIP0: clip_base   <= cfg_data;
        REG_CLIP1: clip_extra  <= cfg_data;
        REG_PEAK:  pixel_peak  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign peak_eff = (pixel_peak > PIX_MAX) ? PIX_MAX : pixel_peak;

  // Absolute difference of two pixels, widened to register width.
  function automatic cfg_word_t abs_diff(logic [W-1:0] a, logic [W-1:0] b);
    logic [W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return CFG_W'(d);
  endfunction

  // Clamp a signed value into 0..top.
  function automatic pix_t sat(logic signed [SW-1:0] v, cfg_word_t top);
    logic signed [SW-1:0] t;
    t = $signed(SW'(top));
    if (v < 0) begin
      return '0;
    end else if (v > t) begin
      return top;
    end else begin
      return PIX_W'(v);
    end
  endfunction

  // Clip a signed value to -lim..lim.
  function automatic logic signed [SW-1:0] clip_sym(logic signed [SW-1:0] v,
                                                    logic signed [SW-1:0] lim);
    if (v > lim) begin
      return lim;
    end else if (v < -lim) begin
      return -lim;
    end else begin
      return v;
    end
  endfunction

  // Stage handshake: a stage may load when it is empty or its item moves on.
  logic rdy1, rdy2, rdy3;
  logic v1, v2, v3;

  assign rdy3        = !v3 || out_ch.ready;
  assign rdy2        = !v2 || rdy3;
  assign rdy1        = !v1 || rdy2;
  assign in_ch.ready = rdy1;

  // --------------------------------------------------------------------------
  // Stage 1: truncate pixels, edge and smoothness decisions, raw delta, avg.
  // --------------------------------------------------------------------------
  logic [W-1:0] a_p2, a_p1, a_p0, a_q0, a_q1, a_q2;
  logic                 a_on, a_sp, a_sq;
  logic [W:0]           a_avg_sum;
  logic signed [SW-1:0] a_dsum, a_dsh;

  assign a_p2 = in_ch.pix_p2[W-1:0];
  assign a_p1 = in_ch.pix_p1[W-1:0];
  assign a_p0 = in_ch.pix_p0[W-1:0];
  assign a_q0 = in_ch.pix_q0[W-1:0];
  assign a_q1 = in_ch.pix_q1[W-1:0];
  assign a_q2 = in_ch.pix_q2[W-1:0];

  always_comb begin
    a_on = (abs_diff(a_p0, a_q0) < alpha_limit) &&
           (abs_diff(a_p1, a_p0) < beta_limit) &&
           (abs_diff(a_q0, a_q1) < beta_limit);
    a_sp = abs_diff(a_p2, a_p0) < beta_limit;
    a_sq = abs_diff(a_q2, a_q0) < beta_limit;
    a_avg_sum = (W+1)'(a_p0) + (W+1)'(a_q0) + (W+1)'(1);
    a_dsum = (($signed(SW'(a_q0)) - $signed(SW'(a_p0))) <<< 2)
           + $signed(SW'(a_p1)) - $signed(SW'(a_q1)) + $signed(SW'(4));
    a_dsh  = a_dsum >>> 3;
  end

  logic [W-1:0]      s1_p2, s1_p1, s1_p0, s1_q0, s1_q1, s1_q2, s1_avg;
  logic              s1_on, s1_sp, s1_sq;
  logic signed [W:0] s1_dlt;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      s1_p2  <= a_p2;
      s1_p1  <= a_p1;
      s1_p0  <= a_p0;
      s1_q0  <= a_q0;
      s1_q1  <= a_q1;
      s1_q2  <= a_q2;
      s1_on  <= a_on;
      s1_sp  <= a_sp;
      s1_sq  <= a_sq;
      s1_avg <= a_avg_sum[W:1];
      s1_dlt <= a_dsh[W:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: clip limit, clipped delta, raw outer-pixel corrections.
  // --------------------------------------------------------------------------
  logic [CFG_W+1:0]     b_c;
  logic signed [SW-1:0] b_dlt, b_e1p, b_e1q;

  always_comb begin
    b_c = (CFG_W+2)'(clip_base)
        + (s1_sp ? (CFG_W+2)'(clip_extra) : '0)
        + (s1_sq ? (CFG_W+2)'(clip_extra) : '0);
    b_dlt = clip_sym(SW'(s1_dlt), $signed(SW'(b_c)));
    b_e1p = ($signed(SW'(s1_p2)) + $signed(SW'(s1_avg))
           - ($signed(SW'(s1_p1)) <<< 1)) >>> 1;
    b_e1q = ($signed(SW'(s1_q2)) + $signed(SW'(s1_avg))
           - ($signed(SW'(s1_q1)) <<< 1)) >>> 1;
  end

  logic [W-1:0]      s2_p1, s2_p0, s2_q0, s2_q1;
  logic              s2_on, s2_sp, s2_sq;
  logic signed [W:0] s2_dlt, s2_dp1, s2_dq1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_p1  <= s1_p1;
      s2_p0  <= s1_p0;
      s2_q0  <= s1_q0;
      s2_q1  <= s1_q1;
      s2_on  <= s1_on;
      s2_sp  <= s1_sp;
      s2_sq  <= s1_sq;
      s2_dlt <= b_dlt[W:0];
      s2_dp1 <= b_e1p[W:0];
      s2_dq1 <= b_e1q[W:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: apply corrections and saturate into the output register.
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] c_c0, c_dp1, c_dq1, c_np1, c_np0, c_nq0, c_nq1;

  always_comb begin
    c_c0  = $signed(SW'(clip_base));
    c_dp1 = clip_sym(SW'(s2_dp1), c_c0);
    c_dq1 = clip_sym(SW'(s2_dq1), c_c0);
    c_np1 = $signed(SW'(s2_p1));
    c_np0 = $signed(SW'(s2_p0));
    c_nq0 = $signed(SW'(s2_q0));
    c_nq1 = $signed(SW'(s2_q1));
    if (s2_on) begin
      c_np0 = c_np0 + SW'(s2_dlt);
      c_nq0 = c_nq0 - SW'(s2_dlt);
      if (s2_sp) begin
        c_np1 = c_np1 + c_dp1;
      end
      if (s2_sq) begin
        c_nq1 = c_nq1 + c_dq1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      out_ch.out_p1 <= sat(c_np1, peak_eff);
      out_ch.out_p0 <= sat(c_np0, peak_eff);
      out_ch.out_q0 <= sat(c_nq0, peak_eff);
      out_ch.out_q1 <= sat(c_nq1, peak_eff);
    end
  end

  assign out_ch.valid = v3;

`ifndef SYNTHESIS
  // A stage-1 item that cannot move on stays put with its decisions intact.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !rdy2) |=> (v1 && $stable(s1_dlt) && $stable(s1_on) && $stable(s1_avg)))
    else $error("stage 1 item changed while stalled");

  // The clipped edge delta never exceeds the clip limit in magnitude.
  a_dlt_clip: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (b_dlt <= $signed(SW'(b_c)) && b_dlt >= -$signed(SW'(b_c))))
    else $error("edge delta outside clip limit");

  // Every delivered pixel lies within the effective peak.
  a_out_peak: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.out_p1 <= peak_eff && out_ch.out_p0 <= peak_eff &&
                      out_ch.out_q0 <= peak_eff && out_ch.out_q1 <= peak_eff))
    else $error("output pixel above peak");
`endif

endmodule
